FILE: src/two_class_queue_cancel_interleave_unit_assert.svh
// Assertion macros for the two-class queue unit
`ifndef TWO_CLASS_QUEUE_CANCEL_INTERLEAVE_UNIT_ASSERT_SVH
`define TWO_CLASS_QUEUE_CANCEL_INTERLEAVE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TCQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcq assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define TCQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcq assertion failed");

`endif

FILE: src/tcq_pkg.sv
// Shared constants, codes and types for the two-class queue unit
package tcq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;
  localparam int ID_FIELD_W  = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 24;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_PUSH   = 2'd0;
  localparam opcode_t OP_CANCEL = 2'd1;
  localparam opcode_t OP_DRAIN  = 2'd2;
  localparam opcode_t OP_NOP    = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_NOT_FOUND = 3'd2;
  localparam status_t ST_DRAINED   = 3'd3;
  localparam status_t ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic capture;
    logic push;
    logic cancel;
    logic rotate;
  } q_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic [ID_WIDTH-1:0] head;
    logic                found;
    logic                full;
  } q_stat_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

endpackage

FILE: src/tcq_cell.sv
// One queue slot: holds an ID, loads the key on a push, compares it to the key, shifts or rotates it
module tcq_cell import tcq_pkg::*; (
  input  logic                clk,
  input  q_cmd_t              cmd,
  input  logic [IDX_W-1:0]    index,
  input  logic [CNT_W-1:0]    count,
  input  logic [ID_WIDTH-1:0] key,
  input  logic [ID_WIDTH-1:0] next_id,
  input  logic [ID_WIDTH-1:0] head_id,
  input  logic                seen_in,
  output logic                seen_out,
  output logic [ID_WIDTH-1:0] id_out
);

  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic                match_r, match_nxt;
  logic                in_range, at_tail, at_wrap;

  assign in_range = CNT_W'(index) < count;
  assign at_tail  = CNT_W'(index) == count;
  assign at_wrap  = (CNT_W'(index) + CNT_W'(1)) == count;
  assign seen_out = seen_in | (match_r & in_range);
  assign id_out   = id_r;

  always_comb begin
    match_nxt = match_r;
    if (cmd.capture) begin
      match_nxt = (id_r == key);
    end
  end

  always_comb begin
    id_nxt = id_r;
    priority if (cmd.push && at_tail) begin
      id_nxt = key;
    end else if (cmd.cancel && seen_out) begin
      id_nxt = next_id;
    end else if (cmd.rotate && in_range) begin
      id_nxt = at_wrap ? head_id : next_id;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    match_r <= match_nxt;
  end

endmodule

FILE: src/tcq_queue.sv
// One class queue: a row of cells plus its fill count
module tcq_queue import tcq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  q_cmd_t              cmd,
  input  logic [ID_WIDTH-1:0] key,
  output q_stat_t             stat
);

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ID_WIDTH-1:0] ids  [QUEUE_DEPTH];
  logic                seen [QUEUE_DEPTH+1];
  logic                full;
  q_cmd_t              cell_cmd;

  assign full    = count_r == CNT_W'(QUEUE_DEPTH);
  assign seen[0] = 1'b0;

  always_comb begin
    cell_cmd      = cmd;
    cell_cmd.push = cmd.push & ~full;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0] nb_id;
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign nb_id = ids[i];
    end else begin : g_mid
      assign nb_id = ids[i+1];
    end
    tcq_cell u_cell (
      .clk      (clk),
      .cmd      (cell_cmd),
      .index    (IDX_W'(i)),
      .count    (count_r),
      .key      (key),
      .next_id  (nb_id),
      .head_id  (ids[0]),
      .seen_in  (seen[i]),
      .seen_out (seen[i+1]),
      .id_out   (ids[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    priority if (cmd.push && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cancel && seen[QUEUE_DEPTH]) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.count = count_r;
  assign stat.head  = ids[0];
  assign stat.found = seen[QUEUE_DEPTH];
  assign stat.full  = full;

endmodule

FILE: src/two_class_queue_cancel_interleave_unit.sv
// Top level: command control, interleaved drain and result register
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tdata: opcode, id_value; tuser: queue_class
//  out_    | out | out_tvalid/out_tready | tdata: status, entry_id; tuser: entry_class; tlast
//
// Push, cancel and unused opcodes are accepted, then executed in the cells.
// A drain emits every stored entry, alternating the classes from class 0; each queue rotates one slot per
// emitted entry and returns to its original order at the end.
// Synchronous active-low reset clears the counts, control and output valid.
// Results wait in one output register; a stalled output holds the unit in execute or drain.
module two_class_queue_cancel_interleave_unit import tcq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [1:0] opcode, [17:2] id_value
  input  logic                  in_tuser,   // [0] queue_class
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] status, [18:3] entry_id
  output logic                  out_tuser,  // [0] entry_class
  output logic                  out_tlast
);

`include "two_class_queue_cancel_interleave_unit_assert.svh"

  state_t              state_r, state_nxt;
  opcode_t             op_r, op_nxt;
  logic [ID_WIDTH-1:0] key_r, key_nxt, key;
  logic                cls_r, cls_nxt;
  logic [CNT_W-1:0]    rem0_r, rem0_nxt, rem1_r, rem1_nxt;
  logic                turn_r, turn_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [ID_WIDTH-1:0] out_id_r, out_id_nxt;
  logic                out_cls_r, out_cls_nxt;
  logic                out_last_r, out_last_nxt;
  q_cmd_t              cmd0, cmd1;
  q_stat_t             st0, st1;
  logic                in_fire, slot_free, pick, emit;
  logic [CNT_W:0]      rem_sum;

  assign in_tready = state_r == S_IDLE;
  assign in_fire   = in_tvalid & in_tready;
  assign slot_free = ~out_valid_r | out_tready;
  assign key       = (state_r == S_IDLE) ? in_tdata[2 +: ID_WIDTH] : key_r;
  assign rem_sum   = (CNT_W+1)'(rem0_r) + (CNT_W+1)'(rem1_r);
  assign pick      = ~((~turn_r && rem0_r != '0) || rem1_r == '0);

  tcq_queue u_q0 (.clk(clk), .rst_n(rst_n), .cmd(cmd0), .key(key), .stat(st0));
  tcq_queue u_q1 (.clk(clk), .rst_n(rst_n), .cmd(cmd1), .key(key), .stat(st1));

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    cls_nxt        = cls_r;
    rem0_nxt       = rem0_r;
    rem1_nxt       = rem1_r;
    turn_nxt       = turn_r;
    emit           = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_cls_nxt    = out_cls_r;
    out_last_nxt   = out_last_r;
    cmd0           = '0;
    cmd1           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt       = in_tdata[1:0];
          key_nxt      = in_tdata[2 +: ID_WIDTH];
          cls_nxt      = in_tuser;
          cmd0.capture = 1'b1;
          cmd1.capture = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          out_id_nxt   = '0;
          out_cls_nxt  = 1'b0;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
          emit         = 1'b1;
          unique case (op_r)
            OP_PUSH: begin
              cmd0.push      = ~cls_r;
              cmd1.push      = cls_r;
              out_status_nxt = (cls_r ? st1.full : st0.full) ? ST_FULL : ST_OK;
            end
            OP_CANCEL: begin
              cmd0.cancel    = ~cls_r;
              cmd1.cancel    = cls_r;
              out_status_nxt = (cls_r ? st1.found : st0.found) ? ST_OK : ST_NOT_FOUND;
            end
            OP_DRAIN: begin
              out_status_nxt = ST_EMPTY;
              if (st0.count != '0 || st1.count != '0) begin
                emit      = 1'b0;
                rem0_nxt  = st0.count;
                rem1_nxt  = st1.count;
                turn_nxt  = 1'b0;
                state_nxt = S_DRAIN;
              end
            end
            OP_NOP: begin
              out_status_nxt = ST_OK;
            end
            default: begin
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_DRAIN: begin
        if (slot_free) begin
          emit           = 1'b1;
          out_status_nxt = ST_DRAINED;
          out_id_nxt     = pick ? st1.head : st0.head;
          out_cls_nxt    = pick;
          out_last_nxt   = rem_sum == (CNT_W+1)'(1);
          cmd0.rotate    = ~pick;
          cmd1.rotate    = pick;
          turn_nxt       = ~pick;
          if (pick) begin
            rem1_nxt = rem1_r - CNT_W'(1);
          end else begin
            rem0_nxt = rem0_r - CNT_W'(1);
          end
          if (out_last_nxt) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    cls_r        <= cls_nxt;
    rem0_r       <= rem0_nxt;
    rem1_r       <= rem1_nxt;
    turn_r       <= turn_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_cls_r    <= out_cls_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-3-ID_FIELD_W)'(0), ID_FIELD_W'(out_id_r), out_status_r};
  assign out_tuser  = out_cls_r;
  assign out_tlast  = out_last_r;

  `TCQ_ASSERT_NOW(a_count_bound, 1'b1, st0.count <= CNT_W'(QUEUE_DEPTH) && st1.count <= CNT_W'(QUEUE_DEPTH))
  `TCQ_ASSERT_NOW(a_drain_has_work, state_r == S_DRAIN, rem_sum != '0)
  `TCQ_ASSERT_NEXT(a_drain_keeps_counts, state_r == S_DRAIN, $stable(st0.count) && $stable(st1.count))

endmodule
